// File: src/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and constants for the adc offset calibration block
// Register indexes, sequencer states, lane control bundle and default sizes.
// ----------------------------------------------------------------------------
package aoc_pkg;

    // default sizes handed to the top level parameters
    localparam int SAMPLE_W_DEF = 32;
    localparam int COUNT_W_DEF  = 16;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int DC_OFF_W   = 32;

    // reset value of the calibration sample count
    localparam int SAMPLE_COUNT_RST = 1024;

    // number of phase current lanes
    localparam int NUM_LANES = 3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_COUNT = 1'b0,
        REG_DC_OFFSET    = 1'b1
    } aoc_reg_idx_t;

    // item sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } aoc_state_t;

    // control bundle from the sequencer to every lane
    typedef struct packed {
        logic load;
        logic accum;
        logic div_start;
    } aoc_lane_ctl_t;

endpackage

// File: src/aoc_subsat.sv
// ----------------------------------------------------------------------------
// aoc_subsat: signed subtract with saturation
// Computes a - b at full precision and clamps to the signed output range.
// ----------------------------------------------------------------------------
module aoc_subsat #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int OW = 32
) (
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [OW-1:0] y
);

    localparam int DW = ((AW > BW) ? AW : BW) + 1;
    localparam logic signed [DW-1:0] HI = {{(DW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [DW-1:0] LO = ~HI;

    logic signed [DW-1:0] a_ext;
    logic signed [DW-1:0] b_ext;
    logic signed [DW-1:0] diff;

    // full precision difference
    assign a_ext = {{(DW-AW){a[AW-1]}}, a};
    assign b_ext = {{(DW-BW){b[BW-1]}}, b};
    assign diff  = a_ext - b_ext;

    // clamp to output range
    always_comb
    begin
        if (diff > HI)
        begin
            y = HI[OW-1:0];
        end
        else if (diff < LO)
        begin
            y = LO[OW-1:0];
        end
        else
        begin
            y = diff[OW-1:0];
        end
    end

endmodule

// File: src/aoc_div.sv
// ----------------------------------------------------------------------------
// aoc_div: serial restoring divider
// Unsigned dividend by unsigned divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aoc_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] trial;
    logic             fits;

    // one restoring step
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        trial    = {1'b0, rem_sh} - {2'b00, dvs_reg};
        fits     = ~trial[DVS_W+1];
        rem_next = fits ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    // iteration count and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !start;
            if (start)
            begin
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/aoc_lane.sv
// ----------------------------------------------------------------------------
// aoc_lane: one phase current lane
// Accumulates samples, divides the sum into an offset and corrects samples.
// ----------------------------------------------------------------------------
module aoc_lane #(
    parameter int SW = 32,
    parameter int CW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aoc_pkg::aoc_lane_ctl_t ctl,
    input  logic signed [SW-1:0]  sample,
    input  logic [CW-1:0]         divisor,
    output logic                  div_done,
    output logic signed [SW-1:0]  corrected
);

    localparam int ACCW = SW + CW;

    logic signed [SW-1:0]   sample_reg;
    logic signed [ACCW-1:0] sum_reg;
    logic signed [ACCW-1:0] sum_next;
    logic                   neg_reg;
    logic signed [SW-1:0]   offset_reg;
    logic signed [SW-1:0]   offset_next;
    logic [ACCW-1:0]        mag;
    logic [ACCW-1:0]        dividend;
    logic [ACCW-1:0]        quotient;
    logic signed [ACCW:0]   q_signed;

    // accumulate and round to nearest by adding half the divisor to the magnitude
    always_comb
    begin
        sum_next = sum_reg + {{CW{sample_reg[SW-1]}}, sample_reg};
        mag      = sum_reg[ACCW-1] ? (~sum_reg + ACCW'(1)) : sum_reg;
        dividend = mag + {{(ACCW-CW+1){1'b0}}, divisor[CW-1:1]};
        q_signed = neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    end

    aoc_div #(
        .DVD_W (ACCW),
        .DVS_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // offset clamp to sample range
    aoc_subsat #(
        .AW (ACCW + 1),
        .BW (1),
        .OW (SW)
    ) u_off_sat (
        .a (q_signed),
        .b (1'b0),
        .y (offset_next)
    );

    // sample minus offset
    aoc_subsat #(
        .AW (SW),
        .BW (SW),
        .OW (SW)
    ) u_corr_sat (
        .a (sample_reg),
        .b (offset_reg),
        .y (corrected)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= '0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.accum)
            begin
                sum_reg <= sum_next;
            end
            if (ctl.div_start)
            begin
                neg_reg <= sum_reg[ACCW-1];
            end
            if (div_done)
            begin
                offset_reg <= offset_next;
            end
        end
    end

    // input sample holding register
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sample_reg <= sample;
        end
    end

endmodule

// File: src/adc_offset_calibration.sv
// ----------------------------------------------------------------------------
// adc_offset_calibration: adc offset calibration by averaging
// Three phase current lanes average their first samples into offsets and
// subtract them; the dc link voltage has a configured offset removed.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, one frame of three phase
//   currents and one dc link voltage each. Every item yields one result on
//   m_tvalid/m_tready/m_tdata with calibration_done on m_tuser.
//   While calibrating, an item takes the sequencer through load, accumulate
//   and output, and its result is registered in the output state; after
//   calibration the accumulate step is skipped. The item that completes
//   calibration additionally runs the three lane dividers in parallel: a
//   start step, then SAMPLE_WIDTH + COUNT_WIDTH quotient bits, one per cycle,
//   then the output step once all three are done. The sequencer handles one
//   item at a time. The output register holds a result until taken, and the
//   next item is accepted meanwhile; a stalled receiver holds the block in
//   its output state once that item is done. Reset clears the sums, sample
//   counter, offsets and done flag and sets the sample count to 1024 and the
//   dc offset to zero. Registers are to be written only while the block is
//   idle, through cfg_we/cfg_index/cfg_data; the user must ensure this, as
//   the block itself does not enforce it.
// ----------------------------------------------------------------------------
module adc_offset_calibration #(
    parameter int SAMPLE_WIDTH = aoc_pkg::SAMPLE_W_DEF,
    parameter int COUNT_WIDTH  = aoc_pkg::COUNT_W_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // phase_u_sample, phase_v_sample, phase_w_sample, dc_voltage_sample
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // corrected_u_current, corrected_v_current, corrected_w_current,
    // corrected_dc_voltage
    output logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]  m_tdata,
    // calibration_done
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic [aoc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [aoc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    localparam int DATA_W = ((4*SW+7)/8)*8;
    localparam int NL     = aoc_pkg::NUM_LANES;

    aoc_pkg::aoc_state_t    state_reg;
    aoc_pkg::aoc_state_t    state_next;
    aoc_pkg::aoc_lane_ctl_t lane_ctl;

    logic [CW-1:0]                   count_cfg_reg;
    logic signed [aoc_pkg::DC_OFF_W-1:0] dc_off_reg;
    logic [CW-1:0]                   seen_reg;
    logic [CW-1:0]                   seen_next;
    logic                            done_reg;
    logic                            done_next;
    logic [CW-1:0]                   target;
    logic [CW-1:0]                   divisor;
    logic                            out_load;
    logic [NL-1:0]                   lane_done;
    logic signed [SW-1:0]            lane_corr [NL];
    logic signed [SW-1:0]            dc_sample_reg;
    logic signed [SW-1:0]            dc_corr;
    logic                            m_tvalid_reg;
    logic [DATA_W-1:0]               m_tdata_reg;
    logic                            m_tuser_reg;
    logic [DATA_W-1:0]               out_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= CW'(aoc_pkg::SAMPLE_COUNT_RST);
            dc_off_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aoc_pkg::REG_SAMPLE_COUNT: count_cfg_reg <= cfg_data[CW-1:0];
                aoc_pkg::REG_DC_OFFSET:    dc_off_reg    <= cfg_data[aoc_pkg::DC_OFF_W-1:0];
                default:                   ;
            endcase
        end
    end

    // calibration target and divisor; a zero count means one sample
    assign target  = (count_cfg_reg == '0) ? CW'(1) : count_cfg_reg;
    assign divisor = (seen_reg == '0) ? CW'(1) : seen_reg;

    // current lanes
    for (genvar i = 0; i < NL; i++)
    begin : g_lane
        aoc_lane #(
            .SW (SW),
            .CW (CW)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (lane_ctl),
            .sample    (s_tdata[i*SW +: SW]),
            .divisor   (divisor),
            .div_done  (lane_done[i]),
            .corrected (lane_corr[i])
        );
    end

    // dc voltage path
    always_ff @(posedge clk)
    begin
        if (lane_ctl.load)
        begin
            dc_sample_reg <= s_tdata[3*SW +: SW];
        end
    end

    aoc_subsat #(
        .AW (SW),
        .BW (aoc_pkg::DC_OFF_W),
        .OW (SW)
    ) u_dc_sat (
        .a (dc_sample_reg),
        .b (dc_off_reg),
        .y (dc_corr)
    );

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aoc_pkg::ST_IDLE;
            seen_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            done_reg  <= done_next;
        end
    end

    // sequencer next state and controls
    always_comb
    begin
        state_next         = state_reg;
        seen_next          = seen_reg;
        done_next          = done_reg;
        lane_ctl           = '0;
        s_tready           = 1'b0;
        out_load           = 1'b0;
        unique case (state_reg)
            aoc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    lane_ctl.load = 1'b1;
                    state_next    = done_reg ? aoc_pkg::ST_OUT : aoc_pkg::ST_ACC;
                end
            end
            aoc_pkg::ST_ACC:
            begin
                lane_ctl.accum = 1'b1;
                seen_next      = seen_reg + CW'(1);
                if ((seen_next >= target) || (seen_next == '0))
                begin
                    state_next = aoc_pkg::ST_DIV_START;
                end
                else
                begin
                    state_next = aoc_pkg::ST_OUT;
                end
            end
            aoc_pkg::ST_DIV_START:
            begin
                lane_ctl.div_start = 1'b1;
                state_next         = aoc_pkg::ST_DIV_WAIT;
            end
            aoc_pkg::ST_DIV_WAIT:
            begin
                if (&lane_done)
                begin
                    done_next  = 1'b1;
                    state_next = aoc_pkg::ST_OUT;
                end
            end
            aoc_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = aoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aoc_pkg::ST_IDLE;
            end
        endcase
    end

    // merge lane results into one output word
    always_comb
    begin
        out_word = '0;
        for (int i = 0; i < NL; i++)
        begin
            out_word[i*SW +: SW] = lane_corr[i];
        end
        out_word[3*SW +: SW] = dc_corr;
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= out_word;
            m_tuser_reg <= done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // once calibration is done it stays done
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("calibration done flag cleared");

    // the three lane dividers finish together
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
        else $error("lane dividers out of step");

    // division only starts while calibration is still running
    a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctl.div_start |-> !done_reg)
        else $error("division started after calibration done");

    // accumulation follows an accepted item
    a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aoc_pkg::ST_ACC) |-> $past(s_tvalid && s_tready))
        else $error("accumulate without accepted item");
`endif

endmodule

// File: verif/adc_offset_calibration_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_offset_calibration_test: self-checking bench for adc offset calibration
// Streams current/voltage items through the block with random gaps and stalls.
// An in-bench model averages the calibration items, rounds the offsets,
// subtracts them with saturation and checks every result field.
// ----------------------------------------------------------------------------
module adc_offset_calibration_test;

    localparam int SW        = aoc_pkg::SAMPLE_W_DEF;
    localparam int CW        = aoc_pkg::COUNT_W_DEF;
    localparam int CFG_W     = aoc_pkg::CFG_DATA_W;
    localparam int IDX_W     = aoc_pkg::CFG_IDX_W;
    localparam int DATA_W    = ((4 * SW + 7) / 8) * 8;
    localparam int LIMIT     = 400000;
    localparam int RAND_RUN  = 450;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    // one frame of samples, last field in the lowest bits
    typedef struct packed {
        logic signed [SW-1:0] dc_link;
        logic signed [SW-1:0] phase_w;
        logic signed [SW-1:0] phase_v;
        logic signed [SW-1:0] phase_u;
    } frame_t;

    typedef struct packed {
        logic   cal_done;
        frame_t data;
    } corrected_t;

    // offset averaging model and store of expected corrected frames
    class offset_predictor;
        logic [CW-1:0]        sample_target;
        logic signed [31:0]   dc_offset;
        longint               acc_u, acc_v, acc_w;
        logic [CW-1:0]        samples;
        bit                   done;
        longint               off_u, off_v, off_w;
        corrected_t           expected_frames[$];
        int                   errors;

        function new();
            sample_target = CW'(aoc_pkg::SAMPLE_COUNT_RST);
            dc_offset     = '0;
            acc_u = 0; acc_v = 0; acc_w = 0;
            samples = '0;
            done    = 1'b0;
            off_u = 0; off_v = 0; off_w = 0;
            errors = 0;
        endfunction

        function void write_reg(aoc_pkg::aoc_reg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                aoc_pkg::REG_SAMPLE_COUNT: sample_target = value[CW-1:0];
                aoc_pkg::REG_DC_OFFSET:    dc_offset     = value[31:0];
                default: ;
            endcase
        endfunction

        static function logic signed [SW-1:0] clamp(longint v);
            if (v > longint'(S_MAX))
                return S_MAX;
            if (v < longint'(S_MIN))
                return S_MIN;
            return v[SW-1:0];
        endfunction

        // nearest, ties away from zero
        static function longint avg_round(longint s, longint n);
            longint mag;
            longint q;
            mag = (s < 0) ? -s : s;
            q   = (mag + n / 2) / n;
            return (s < 0) ? -q : q;
        endfunction

        function void add_frame(frame_t f);
            longint     target;
            longint     n;
            corrected_t r;
            if (!done)
            begin
                target = (sample_target == '0) ? 1 : longint'(sample_target);
                acc_u += longint'(f.phase_u);
                acc_v += longint'(f.phase_v);
                acc_w += longint'(f.phase_w);
                samples = samples + 1'b1;
                if (longint'(samples) >= target || samples == '0)
                begin
                    n     = (samples == '0) ? 1 : longint'(samples);
                    off_u = clamp(avg_round(acc_u, n));
                    off_v = clamp(avg_round(acc_v, n));
                    off_w = clamp(avg_round(acc_w, n));
                    done  = 1'b1;
                end
            end
            r.data.phase_u = clamp(longint'(f.phase_u) - off_u);
            r.data.phase_v = clamp(longint'(f.phase_v) - off_v);
            r.data.phase_w = clamp(longint'(f.phase_w) - off_w);
            r.data.dc_link = clamp(longint'(f.dc_link) - longint'(dc_offset));
            r.cal_done     = done;
            expected_frames.push_back(r);
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void compare_frame(logic [DATA_W-1:0] data, logic done_bit);
            corrected_t want;
            frame_t     got;
            if (expected_frames.size() == 0)
            begin
                $error("unexpected result item, nothing pending");
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            got  = data[4*SW-1:0];
            if (got.phase_u !== want.data.phase_u)
            begin
                $error("corrected_u_current: expected %0d, got %0d",
                       want.data.phase_u, got.phase_u);
                errors++;
            end
            if (got.phase_v !== want.data.phase_v)
            begin
                $error("corrected_v_current: expected %0d, got %0d",
                       want.data.phase_v, got.phase_v);
                errors++;
            end
            if (got.phase_w !== want.data.phase_w)
            begin
                $error("corrected_w_current: expected %0d, got %0d",
                       want.data.phase_w, got.phase_w);
                errors++;
            end
            if (got.dc_link !== want.data.dc_link)
            begin
                $error("corrected_dc_voltage: expected %0d, got %0d",
                       want.data.dc_link, got.dc_link);
                errors++;
            end
            if (done_bit !== want.cal_done)
            begin
                $error("calibration_done: expected %0d, got %0d", want.cal_done, done_bit);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic [DATA_W-1:0]      s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_we;
    logic [IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    offset_predictor        pred = new();
    bit                     steady = 1'b0;
    int                     cycles = 0;

    adc_offset_calibration u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pred.compare_frame(m_tdata, m_tuser);
    end

    function automatic int unsigned pick_gap();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic frame_t make_frame(logic [SW-1:0] u, logic [SW-1:0] v,
                                          logic [SW-1:0] w, logic [SW-1:0] dc);
        frame_t f;
        f.phase_u = u;
        f.phase_v = v;
        f.phase_w = w;
        f.dc_link = dc;
        return f;
    endfunction

    // mostly full range, with extremes and small values mixed in
    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SW'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // receiver stalls
    initial
    begin
        int unsigned gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap();
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic push_frame(frame_t f);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= DATA_W'(f);
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pred.add_frame(f);
    endtask

    // stop sending and wait until every corrected frame is back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pred.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(aoc_pkg::aoc_reg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred.write_reg(idx, value);
        @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        longint n;
        longint half;
        longint ru;
        longint rv;
        int     n_cal;

        rst_n     <= 1'b0;
        s_tdata   <= '0;
        s_tvalid  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= aoc_pkg::REG_SAMPLE_COUNT;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // longest calibration, most negative voltage offset
        write_reg(aoc_pkg::REG_SAMPLE_COUNT, CFG_W'(16'hFFFF));
        write_reg(aoc_pkg::REG_DC_OFFSET, CFG_W'(S_MIN));

        // extremes while calibrating: currents pass through unchanged
        push_frame(make_frame('0, '0, '0, '0));
        push_frame(make_frame(S_MAX, S_MAX, S_MAX, S_MAX));
        push_frame(make_frame(S_MIN, S_MIN, S_MIN, S_MIN));
        push_frame(make_frame(S_MAX, S_MIN, 1, '1));
        push_frame(make_frame('1, 1, S_MIN, S_MAX));
        push_frame(make_frame(1, '1, '0, S_MIN));

        // random calibration items, u positive and v negative for large offsets
        n_cal = $urandom_range(100, 300);
        repeat (n_cal)
            push_frame(make_frame($urandom_range(0, 32'h7FFF_FFFF),
                                  {1'b1, 31'($urandom())}, $urandom(), $urandom()));
        // keep the final divisor even so that a tie can be built
        if (pred.samples[0] == 1'b0)
            push_frame(make_frame($urandom_range(0, 32'h7FFF_FFFF),
                                  {1'b1, 31'($urandom())}, $urandom(), $urandom()));
        wait_results_drained();

        // count lowered below the samples taken, zero count: next item ends it
        write_reg(aoc_pkg::REG_SAMPLE_COUNT, '0);
        n    = longint'(pred.samples) + 1;
        half = n / 2;
        ru   = ((half - pred.acc_u) % n + n) % n;
        rv   = ((half - pred.acc_v) % n + n) % n;
        // u and v sums land exactly on a half: positive and negative ties
        push_frame(make_frame(SW'(ru), SW'(rv - n), $urandom(), $urandom()));
        wait_results_drained();

        // saturation against the computed offsets and the largest voltage offset
        write_reg(aoc_pkg::REG_DC_OFFSET, CFG_W'(S_MAX));
        push_frame(make_frame(S_MIN, S_MAX, S_MIN, S_MIN));
        push_frame(make_frame(S_MAX, S_MIN, S_MAX, S_MAX));
        push_frame(make_frame('0, '0, '0, '0));
        push_frame(make_frame(SW'(pred.off_u), SW'(pred.off_v), SW'(pred.off_w), '1));
        push_frame(make_frame(1, '1, S_MAX, '0));
        wait_results_drained();

        // a count written after calibration changes nothing
        write_reg(aoc_pkg::REG_SAMPLE_COUNT, CFG_W'(1));
        write_reg(aoc_pkg::REG_DC_OFFSET, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            steady = (phase == 1);
            if (phase == 1)
                write_reg(aoc_pkg::REG_DC_OFFSET, $urandom());
            else if (phase == 2)
                write_reg(aoc_pkg::REG_DC_OFFSET, CFG_W'(S_MIN));
            else if (phase == 3)
            begin
                write_reg(aoc_pkg::REG_SAMPLE_COUNT, $urandom_range(1, 16'hFFFF));
                write_reg(aoc_pkg::REG_DC_OFFSET, $urandom());
            end
            repeat (RAND_RUN)
                push_frame(make_frame(rand_sample(), rand_sample(), rand_sample(),
                                      rand_sample()));
            wait_results_drained();
        end

        steady = 1'b0;
        repeat (60) @(posedge clk);
        if (pred.errors == 0 && pred.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/aoc_pkg.sv
src/aoc_subsat.sv
src/aoc_div.sv
src/aoc_lane.sv
src/adc_offset_calibration.sv
verif/adc_offset_calibration_test.sv
